// ===== rtl/tilt_angle_motor_correction_unit_assert.svh =====
// Assertion macros for the tilt-angle motor correction RTL, included by tamc_drive.
`ifndef TILT_ANGLE_MOTOR_CORRECTION_UNIT_ASSERT_SVH
`define TILT_ANGLE_MOTOR_CORRECTION_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TAMC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Checks that a condition never occurs.
`define TAMC_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== rtl/tamc_pkg.sv =====
// Package with shared types, constants and the arctangent table.
package tamc_pkg;
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_FRAC  = 30;
   localparam int CORDIC_SCALE = 32;
   localparam int ACC_W        = 33;
   localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 33'sd1686629713;

   localparam int DRIVE_W     = 8;
   localparam int GAIN_W      = 12;
   localparam int CORR_W      = 17;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 2;

   localparam logic [DRIVE_W-1:0] BASE_THROTTLE_RESET    = 8'd35;
   localparam logic [GAIN_W-1:0]  GAIN_RESET             = 12'd3072;
   localparam logic [DRIVE_W-1:0] CORRECTION_LIMIT_RESET = 8'd8;
   localparam logic [DRIVE_W-1:0] MOTOR_MAX_RESET        = 8'd75;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_THROTTLE    = 2'd0,
      CSR_GAIN             = 2'd1,
      CSR_CORRECTION_LIMIT = 2'd2,
      CSR_MOTOR_MAX        = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DRIVE_W-1:0] base_throttle;
      logic [GAIN_W-1:0]  gain_q4_8;
      logic [DRIVE_W-1:0] correction_limit;
      logic [DRIVE_W-1:0] motor_max;
   } drive_cfg_type;

   // Returns atan(2^-i) in Q2.30, rounded to nearest.
   function automatic logic [31:0] atan_q30(input int unsigned i);
      logic [31:0] val;
      case (i)
         0: val = 32'd843314857;
         1: val = 32'd497837829;
         2: val = 32'd263043837;
         3: val = 32'd133525159;
         4: val = 32'd67021687;
         5: val = 32'd33543516;
         6: val = 32'd16775851;
         7: val = 32'd8388437;
         8: val = 32'd4194283;
         9: val = 32'd2097149;
         default: val = (i < 31) ? (32'd1 << (30 - i)) : 32'd0;
      endcase
      return val;
   endfunction
endpackage

// ===== rtl/tilt_angle_motor_correction_unit.sv =====
// Top level of the tilt-angle motor correction pipeline with its control registers.
// The unit takes one accelerometer request per cycle unless a stall holds req_ready low,
// and returns one result per request. A square stage and a sum stage form the squared sum,
// one root bit is resolved per stage, 30 CORDIC stages and a rounding stage produce the
// pitch, and three stages apply gain, clamp and drive limits. Every stage holds its request
// while the next one is stalled, so requests keep entering while earlier results wait,
// until every stage is full. Control registers should be written only while no request is in flight.
module tilt_angle_motor_correction_unit
   import tamc_pkg::*;
#(
   parameter int AXIS_WIDTH      = 16,
   parameter int ANGLE_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [AXIS_WIDTH-1:0]      req_accel_x,
   input  logic signed [AXIS_WIDTH-1:0]      req_accel_y,
   input  logic signed [AXIS_WIDTH-1:0]      req_accel_z,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ANGLE_FRAC_BITS+1:0] rsp_pitch_angle,
   output logic signed [CORR_W-1:0]          rsp_correction_q8,
   output logic [DRIVE_W-1:0]                rsp_left_drive,
   output logic [DRIVE_W-1:0]                rsp_right_drive,
   input  logic                              csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0]             csr_write_data
);
   drive_cfg_type cfg_ff;
   drive_cfg_type cfg_in;

   logic                              root_valid;
   logic                              root_ready;
   logic signed [AXIS_WIDTH-1:0]      root_x;
   logic [AXIS_WIDTH-1:0]             root_val;
   logic                              pitch_valid;
   logic                              pitch_ready;
   logic signed [ANGLE_FRAC_BITS+1:0] pitch_val;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_BASE_THROTTLE:    cfg_in.base_throttle    = csr_write_data[DRIVE_W-1:0];
            CSR_GAIN:             cfg_in.gain_q4_8        = csr_write_data[GAIN_W-1:0];
            CSR_CORRECTION_LIMIT: cfg_in.correction_limit = csr_write_data[DRIVE_W-1:0];
            CSR_MOTOR_MAX:        cfg_in.motor_max        = csr_write_data[DRIVE_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_throttle    <= BASE_THROTTLE_RESET;
         cfg_ff.gain_q4_8        <= GAIN_RESET;
         cfg_ff.correction_limit <= CORRECTION_LIMIT_RESET;
         cfg_ff.motor_max        <= MOTOR_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tamc_root #(
      .AXIS_WIDTH(AXIS_WIDTH)
   ) u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_x      (req_accel_x),
      .in_y      (req_accel_y),
      .in_z      (req_accel_z),
      .out_valid (root_valid),
      .out_ready (root_ready),
      .out_x     (root_x),
      .out_root  (root_val)
   );

   tamc_cordic #(
      .AXIS_WIDTH      (AXIS_WIDTH),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (root_valid),
      .in_ready  (root_ready),
      .in_x      (root_x),
      .in_root   (root_val),
      .out_valid (pitch_valid),
      .out_ready (pitch_ready),
      .out_pitch (pitch_val)
   );

   tamc_drive #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) u_drive (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .in_valid       (pitch_valid),
      .in_ready       (pitch_ready),
      .in_pitch       (pitch_val),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_pitch      (rsp_pitch_angle),
      .out_correction (rsp_correction_q8),
      .out_left       (rsp_left_drive),
      .out_right      (rsp_right_drive)
   );
endmodule

// ===== rtl/tamc_root.sv =====
// Pipelined squares and restoring integer square root of y*y + z*z.
module tamc_root
   import tamc_pkg::*;
#(
   parameter int AXIS_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [AXIS_WIDTH-1:0] in_x,
   input  logic signed [AXIS_WIDTH-1:0] in_y,
   input  logic signed [AXIS_WIDTH-1:0] in_z,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [AXIS_WIDTH-1:0] out_x,
   output logic [AXIS_WIDTH-1:0]        out_root
);
   localparam int AW = AXIS_WIDTH;
   localparam int SW = 2 * AW;
   localparam int NS = AW + 2;

   logic [SW-1:0]        rem_ff  [NS];
   logic [SW-1:0]        zsq_ff;
   logic [AW-1:0]        root_ff [NS];
   logic signed [AW-1:0] x_ff    [NS];
   logic                 v_ff    [NS];
   logic                 adv     [NS];

   genvar s;
   generate
      for (s = 0; s < NS; s++) begin : g_stage
         if (s == NS - 1) begin : g_last
            assign adv[s] = !v_ff[s] || out_ready;
         end else begin : g_mid
            assign adv[s] = !v_ff[s] || adv[s+1];
         end

         if (s == 0) begin : g_square
            logic signed [SW-1:0] ysq;
            logic signed [SW-1:0] zsq;
            assign ysq = in_y * in_y;
            assign zsq = in_z * in_z;
            always_ff @(posedge clock) begin
               if (reset) begin
                  v_ff[s] <= 1'b0;
               end else if (adv[s]) begin
                  v_ff[s] <= in_valid;
               end
               if (adv[s]) begin
                  rem_ff[s]  <= $unsigned(ysq);
                  zsq_ff     <= $unsigned(zsq);
                  root_ff[s] <= '0;
                  x_ff[s]    <= in_x;
               end
            end
         end else if (s == 1) begin : g_sum
            always_ff @(posedge clock) begin
               if (reset) begin
                  v_ff[s] <= 1'b0;
               end else if (adv[s]) begin
                  v_ff[s] <= v_ff[s-1];
               end
               if (adv[s]) begin
                  rem_ff[s]  <= rem_ff[s-1] + zsq_ff;
                  root_ff[s] <= root_ff[s-1];
                  x_ff[s]    <= x_ff[s-1];
               end
            end
         end else begin : g_bit
            localparam int K = AW + 1 - s;
            logic [SW+1:0] trial;
            logic          fits;
            assign trial = ({{(AW+2){1'b0}}, root_ff[s-1]} << (K + 1))
                         + ((SW+2)'(1) << (2 * K));
            assign fits  = {2'b00, rem_ff[s-1]} >= trial;
            always_ff @(posedge clock) begin
               if (reset) begin
                  v_ff[s] <= 1'b0;
               end else if (adv[s]) begin
                  v_ff[s] <= v_ff[s-1];
               end
               if (adv[s]) begin
                  rem_ff[s]  <= fits ? SW'({2'b00, rem_ff[s-1]} - trial) : rem_ff[s-1];
                  root_ff[s] <= fits ? (root_ff[s-1] | (AW'(1) << K)) : root_ff[s-1];
                  x_ff[s]    <= x_ff[s-1];
               end
            end
         end
      end
   endgenerate

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];
   assign out_x     = x_ff[NS-1];
   assign out_root  = root_ff[NS-1];
endmodule

// ===== rtl/tamc_cordic.sv =====
// Pipelined vectoring CORDIC that turns x and the root into a rounded pitch angle.
module tamc_cordic
   import tamc_pkg::*;
#(
   parameter int AXIS_WIDTH      = 16,
   parameter int ANGLE_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [AXIS_WIDTH-1:0]      in_x,
   input  logic [AXIS_WIDTH-1:0]             in_root,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [ANGLE_FRAC_BITS+1:0] out_pitch
);
   localparam int AW = AXIS_WIDTH;
   localparam int PW = ANGLE_FRAC_BITS + 2;
   localparam int CW = AW + 36;
   localparam int RS = CORDIC_FRAC - ANGLE_FRAC_BITS;
   localparam int NS = CORDIC_STEPS + 1;

   logic signed [CW-1:0]    vx_ff  [CORDIC_STEPS];
   logic signed [CW-1:0]    vy_ff  [CORDIC_STEPS];
   logic signed [ACC_W-1:0] acc_ff [CORDIC_STEPS];
   logic                    xz_ff  [CORDIC_STEPS];
   logic                    rz_ff  [CORDIC_STEPS];
   logic                    xn_ff  [CORDIC_STEPS];
   logic signed [PW-1:0]    pitch_ff;
   logic                    v_ff   [NS];
   logic                    adv    [NS];

   genvar s;
   generate
      for (s = 0; s < NS; s++) begin : g_ctl
         if (s == NS - 1) begin : g_last
            assign adv[s] = !v_ff[s] || out_ready;
         end else begin : g_mid
            assign adv[s] = !v_ff[s] || adv[s+1];
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[s] <= 1'b0;
            end else if (adv[s]) begin
               v_ff[s] <= (s == 0) ? in_valid : v_ff[(s == 0) ? 0 : s - 1];
            end
         end
      end

      for (s = 0; s < CORDIC_STEPS; s++) begin : g_iter
         logic signed [CW-1:0]    vx_p;
         logic signed [CW-1:0]    vy_p;
         logic signed [ACC_W-1:0] acc_p;
         logic signed [CW-1:0]    dx;
         logic signed [CW-1:0]    dy;
         logic signed [ACC_W-1:0] ang;
         logic                    xz_p;
         logic                    rz_p;
         logic                    xn_p;
         if (s == 0) begin : g_load
            assign vx_p  = $signed({{(CW-AW-CORDIC_SCALE){1'b0}}, in_root,
                                    {CORDIC_SCALE{1'b0}}});
            assign vy_p  = $signed({{(CW-AW-CORDIC_SCALE){in_x[AW-1]}}, in_x,
                                    {CORDIC_SCALE{1'b0}}});
            assign acc_p = '0;
            assign xz_p  = (in_x == '0);
            assign rz_p  = (in_root == '0);
            assign xn_p  = in_x[AW-1];
         end else begin : g_chain
            assign vx_p  = vx_ff[s-1];
            assign vy_p  = vy_ff[s-1];
            assign acc_p = acc_ff[s-1];
            assign xz_p  = xz_ff[s-1];
            assign rz_p  = rz_ff[s-1];
            assign xn_p  = xn_ff[s-1];
         end
         assign dx  = vy_p >>> s;
         assign dy  = vx_p >>> s;
         assign ang = $signed({1'b0, atan_q30(s)});
         always_ff @(posedge clock) begin
            if (adv[s]) begin
               if (!vy_p[CW-1]) begin
                  vx_ff[s]  <= vx_p + dx;
                  vy_ff[s]  <= vy_p - dy;
                  acc_ff[s] <= acc_p + ang;
               end else begin
                  vx_ff[s]  <= vx_p - dx;
                  vy_ff[s]  <= vy_p + dy;
                  acc_ff[s] <= acc_p - ang;
               end
               xz_ff[s] <= xz_p;
               rz_ff[s] <= rz_p;
               xn_ff[s] <= xn_p;
            end
         end
      end
   endgenerate

   logic signed [ACC_W-1:0] sel_angle;
   logic signed [ACC_W-1:0] rounded;

   always_comb begin
      if (xz_ff[CORDIC_STEPS-1]) begin
         sel_angle = '0;
      end else if (rz_ff[CORDIC_STEPS-1]) begin
         sel_angle = xn_ff[CORDIC_STEPS-1] ? -HALF_PI_Q30 : HALF_PI_Q30;
      end else begin
         sel_angle = acc_ff[CORDIC_STEPS-1];
      end
      rounded = (sel_angle + (ACC_W'(1) << (RS - 1))) >>> RS;
   end

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         pitch_ff <= rounded[PW-1:0];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];
   assign out_pitch = pitch_ff;
endmodule

// ===== rtl/tamc_drive.sv =====
// Gain, correction clamp and motor drive stages with the result register.
module tamc_drive
   import tamc_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  drive_cfg_type                     cfg,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [ANGLE_FRAC_BITS+1:0] in_pitch,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [ANGLE_FRAC_BITS+1:0] out_pitch,
   output logic signed [CORR_W-1:0]          out_correction,
   output logic [DRIVE_W-1:0]                out_left,
   output logic [DRIVE_W-1:0]                out_right
);
`include "tilt_angle_motor_correction_unit_assert.svh"

   localparam int PW     = ANGLE_FRAC_BITS + 2;
   localparam int PROD_W = PW + GAIN_W;
   localparam int NS     = 3;
   localparam int VW     = CORR_W + 2;

   logic                 v_ff [NS];
   logic                 adv  [NS];
   logic [PROD_W-1:0]    prod_ff;
   logic                 neg_ff;
   logic signed [PW-1:0] pitch0_ff;
   logic signed [PW-1:0] pitch1_ff;
   logic signed [PW-1:0] pitch2_ff;
   logic signed [CORR_W-1:0] corr1_ff;
   logic signed [CORR_W-1:0] corr2_ff;
   logic [DRIVE_W-1:0]   left_ff;
   logic [DRIVE_W-1:0]   right_ff;

   logic [PW-1:0]        mag_in;
   logic [PROD_W-1:0]    prod_in;
   logic [CORR_W-1:0]    mag_sh;
   logic [CORR_W-1:0]    lim;
   logic [CORR_W-1:0]    mag_c;
   logic signed [CORR_W-1:0] corr_in;
   logic signed [VW-1:0] base_v;
   logic signed [VW-1:0] corr_v;
   logic [DRIVE_W-1:0]   left_in;
   logic [DRIVE_W-1:0]   right_in;

   function automatic logic [DRIVE_W-1:0] drive_of(input logic signed [VW-1:0] v,
                                                    input logic [DRIVE_W-1:0] max_d);
      logic signed [VW-1:0] d;
      d = v >>> 8;
      if (v <= 0) begin
         return '0;
      end else if (d > $signed({{(VW-DRIVE_W){1'b0}}, max_d})) begin
         return max_d;
      end
      return d[DRIVE_W-1:0];
   endfunction

   assign adv[2] = !v_ff[2] || out_ready;
   assign adv[1] = !v_ff[1] || adv[2];
   assign adv[0] = !v_ff[0] || adv[1];

   always_comb begin
      mag_in   = in_pitch[PW-1] ? PW'(-in_pitch) : PW'(in_pitch);
      prod_in  = PROD_W'(mag_in) * PROD_W'(cfg.gain_q4_8);
      mag_sh   = CORR_W'(prod_ff >> ANGLE_FRAC_BITS);
      lim      = CORR_W'({cfg.correction_limit, 8'h00});
      mag_c    = (mag_sh > lim) ? lim : mag_sh;
      corr_in  = neg_ff ? -$signed(mag_c) : $signed(mag_c);
      base_v   = $signed(VW'({cfg.base_throttle, 8'h00}));
      corr_v   = VW'(corr1_ff);
      left_in  = drive_of(base_v - corr_v, cfg.motor_max);
      right_in = drive_of(base_v + corr_v, cfg.motor_max);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
         v_ff[1] <= 1'b0;
         v_ff[2] <= 1'b0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= in_valid;
         end
         if (adv[1]) begin
            v_ff[1] <= v_ff[0];
         end
         if (adv[2]) begin
            v_ff[2] <= v_ff[1];
         end
      end
      if (adv[0]) begin
         prod_ff   <= prod_in;
         neg_ff    <= in_pitch[PW-1];
         pitch0_ff <= in_pitch;
      end
      if (adv[1]) begin
         corr1_ff  <= corr_in;
         pitch1_ff <= pitch0_ff;
      end
      if (adv[2]) begin
         corr2_ff  <= corr1_ff;
         pitch2_ff <= pitch1_ff;
         left_ff   <= left_in;
         right_ff  <= right_in;
      end
   end

   assign in_ready       = adv[0];
   assign out_valid      = v_ff[2];
   assign out_pitch      = pitch2_ff;
   assign out_correction = corr2_ff;
   assign out_left       = left_ff;
   assign out_right      = right_ff;

   `TAMC_ASSERT_IMPLIES(a_left_max, clock, reset, v_ff[2], left_ff <= cfg.motor_max)
   `TAMC_ASSERT_IMPLIES(a_right_max, clock, reset, v_ff[2], right_ff <= cfg.motor_max)
   `TAMC_ASSERT_IMPLIES(a_zero_pitch, clock, reset, v_ff[2] && pitch2_ff == '0, corr2_ff == '0)
   `TAMC_ASSERT_NEVER(a_corr_sign, clock, reset, v_ff[2] && pitch2_ff > 0 && corr2_ff < 0)
endmodule
